@@ rtl/core/pps_pkg.sv @@
package pps_pkg;

   // Table size and the widths that follow from it.
   localparam int MAX_PROCESSES = 16;
   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

   // Fixed field widths of the request and response.
   localparam int TIME_W = 16;
   localparam int PRI_W  = 8;
   localparam int RID_W  = 4;

   // Request operation codes.
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // One row of the process table.
   typedef struct packed {
      logic              started;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
      logic [PRI_W-1:0]  priority_level;
      logic [TIME_W-1:0] response;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Status the scan unit hands back to the control.
   typedef struct packed {
      logic             done;
      logic             found;
      logic [IDX_W-1:0] best_id;
   } scan_status_type;

endpackage

@@ rtl/core/pps_ram.sv @@
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pps_scan.sv @@
module pps_scan import pps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              scan_start,
   input  logic [TIME_W-1:0] now,
   input  logic [CNT_W-1:0]  loaded_count,
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_addr,
   input  entry_type         rd_data,
   output scan_status_type   status,
   output entry_type         best_entry
);

   logic             active_ff, active_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_id_ff, pend_id_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_id_ff, best_id_in;
   entry_type        best_ff, best_in;
   logic             ready;
   logic             better;
   logic             done;

   assign rd_en   = active_ff && (issue_ff < loaded_count);
   assign rd_addr = issue_ff[IDX_W-1:0];
   assign done    = active_ff && !rd_en && !pend_ff;

   // A row competes only if it has arrived and still has work. Rows come
   // in index order, so a strict compare keeps the lower id on a full tie.
   assign ready  = (rd_data.remaining != '0) && (rd_data.arrival <= now);
   assign better = !found_ff
                || (rd_data.priority_level < best_ff.priority_level)
                || ((rd_data.priority_level == best_ff.priority_level)
                    && (rd_data.arrival < best_ff.arrival));

   always_comb begin
      active_in  = active_ff;
      issue_in   = issue_ff;
      pend_in    = 1'b0;
      pend_id_in = pend_id_ff;
      found_in   = found_ff;
      best_id_in = best_id_ff;
      best_in    = best_ff;
      if (scan_start) begin
         active_in = 1'b1;
         issue_in  = '0;
         found_in  = 1'b0;
      end else begin
         if (rd_en) begin
            issue_in   = issue_ff + CNT_W'(1);
            pend_in    = 1'b1;
            pend_id_in = issue_ff[IDX_W-1:0];
         end
         if (pend_ff && ready && better) begin
            found_in   = 1'b1;
            best_id_in = pend_id_ff;
            best_in    = rd_data;
         end
         if (done) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         issue_ff  <= '0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
         issue_ff  <= issue_in;
      end
      pend_id_ff <= pend_id_in;
      best_id_ff <= best_id_in;
      best_ff    <= best_in;
   end

   assign status.done    = done;
   assign status.found   = found_ff;
   assign status.best_id = best_id_ff;
   assign best_entry     = best_ff;

endmodule

@@ rtl/core/preemptive_priority_scheduler_unit.sv @@
// Preemptive priority scheduler. Requests are taken when start is high and
// busy is low. An add request (operation 0) loads one process into the next
// free row of a sixteen-row table and never raises busy; an add to a full
// table is dropped. A tick request (operation 1) raises busy while the
// table is scanned through its single read port, one row per cycle, and is
// followed by a read-modify-write update of the chosen row, if one was
// found. The time busy stays high grows with the number of loaded rows.
// Each tick gives exactly one response, marked by a one-cycle rsp_valid
// strobe in the same cycle in which busy falls. There is no backpressure on
// the response side: the receiver must capture the response in that cycle.
// Process state lives in one synchronous RAM; rows above the load count are
// never read, so the table needs no clearing after reset.
module preemptive_priority_scheduler_unit import pps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [TIME_W-1:0] req_arrival_time,
   input  logic [TIME_W-1:0] req_burst_length,
   input  logic [PRI_W-1:0]  req_priority_level,
   output logic              rsp_valid,
   output logic [TIME_W-1:0] rsp_tick_time,
   output logic              rsp_idle,
   output logic [RID_W-1:0]  rsp_running_id,
   output logic              rsp_finished,
   output logic [TIME_W-1:0] rsp_completion_time,
   output logic [TIME_W-1:0] rsp_turnaround,
   output logic [TIME_W-1:0] rsp_waiting,
   output logic [TIME_W-1:0] rsp_response,
   output logic              rsp_all_done
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [CNT_W-1:0]  finished_ff, finished_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_tick_time_ff, rsp_tick_time_in;
   logic              rsp_idle_ff, rsp_idle_in;
   logic [RID_W-1:0]  rsp_running_id_ff, rsp_running_id_in;
   logic              rsp_finished_ff, rsp_finished_in;
   logic [TIME_W-1:0] rsp_completion_time_ff, rsp_completion_time_in;
   logic [TIME_W-1:0] rsp_turnaround_ff, rsp_turnaround_in;
   logic [TIME_W-1:0] rsp_waiting_ff, rsp_waiting_in;
   logic [TIME_W-1:0] rsp_response_ff, rsp_response_in;
   logic              rsp_all_done_ff, rsp_all_done_in;

   logic              accept;
   logic              scan_start;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         rd_data;
   logic [ENTRY_W-1:0] rd_word;
   scan_status_type   scan_status;
   entry_type         best;

   // Figures for the row that runs in the update cycle.
   logic [TIME_W-1:0] rem_next;
   logic [TIME_W-1:0] resp_val;
   logic [TIME_W-1:0] comp_val;
   logic [TIME_W-1:0] tat_val;
   logic              completes;
   entry_type         add_entry;
   entry_type         run_entry;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign scan_start = accept && (req_operation == OP_TICK);

   assign rem_next  = best.remaining - TIME_W'(1);
   assign resp_val  = best.started ? best.response : (time_ff - best.arrival);
   assign comp_val  = time_ff + TIME_W'(1);
   assign tat_val   = comp_val - best.arrival;
   assign completes = scan_status.found && (rem_next == '0);

   always_comb begin
      add_entry.started        = 1'b0;
      add_entry.arrival        = req_arrival_time;
      add_entry.burst          = req_burst_length;
      add_entry.remaining      = req_burst_length;
      add_entry.priority_level = req_priority_level;
      add_entry.response       = '0;

      run_entry           = best;
      run_entry.started   = 1'b1;
      run_entry.remaining = rem_next;
      run_entry.response  = resp_val;
   end

   always_comb begin
      state_in    = state_ff;
      time_in     = time_ff;
      loaded_in   = loaded_ff;
      finished_in = finished_ff;
      wr_en       = 1'b0;
      wr_addr     = loaded_ff[IDX_W-1:0];
      wr_data     = add_entry;

      rsp_valid_in           = 1'b0;
      rsp_tick_time_in       = rsp_tick_time_ff;
      rsp_idle_in            = rsp_idle_ff;
      rsp_running_id_in      = rsp_running_id_ff;
      rsp_finished_in        = rsp_finished_ff;
      rsp_completion_time_in = rsp_completion_time_ff;
      rsp_turnaround_in      = rsp_turnaround_ff;
      rsp_waiting_in         = rsp_waiting_ff;
      rsp_response_in        = rsp_response_ff;
      rsp_all_done_in        = rsp_all_done_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_TICK) begin
                  state_in = ST_SCAN;
               end else if (loaded_ff < CNT_W'(MAX_PROCESSES)) begin
                  // A process with no work counts as finished right away.
                  wr_en     = 1'b1;
                  loaded_in = loaded_ff + CNT_W'(1);
                  if (req_burst_length == '0) begin
                     finished_in = finished_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_status.done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
            time_in  = comp_val;
            if (scan_status.found) begin
               wr_en   = 1'b1;
               wr_addr = scan_status.best_id;
               wr_data = run_entry;
            end
            if (completes) begin
               finished_in = finished_ff + CNT_W'(1);
            end
            rsp_valid_in           = 1'b1;
            rsp_tick_time_in       = time_ff;
            rsp_idle_in            = !scan_status.found;
            rsp_running_id_in      = scan_status.found ? RID_W'(scan_status.best_id) : '0;
            rsp_finished_in        = completes;
            rsp_completion_time_in = completes ? comp_val : '0;
            rsp_turnaround_in      = completes ? tat_val : '0;
            rsp_waiting_in         = completes ? (tat_val - best.burst) : '0;
            rsp_response_in        = completes ? resp_val : '0;
            rsp_all_done_in        = (finished_in == loaded_ff);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         loaded_ff    <= '0;
         finished_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         loaded_ff    <= loaded_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_tick_time_ff       <= rsp_tick_time_in;
      rsp_idle_ff            <= rsp_idle_in;
      rsp_running_id_ff      <= rsp_running_id_in;
      rsp_finished_ff        <= rsp_finished_in;
      rsp_completion_time_ff <= rsp_completion_time_in;
      rsp_turnaround_ff      <= rsp_turnaround_in;
      rsp_waiting_ff         <= rsp_waiting_in;
      rsp_response_ff        <= rsp_response_in;
      rsp_all_done_ff        <= rsp_all_done_in;
   end

   // The process table. Writes and scan reads never touch the same row in
   // the same cycle: adds happen only while idle, and the write-back of a
   // tick comes after its scan has finished.
   pps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PROCESSES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_data = rd_word;

   pps_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .scan_start   (scan_start),
      .now          (time_ff),
      .loaded_count (loaded_ff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .status       (scan_status),
      .best_entry   (best)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tick_time       = rsp_tick_time_ff;
   assign rsp_idle            = rsp_idle_ff;
   assign rsp_running_id      = rsp_running_id_ff;
   assign rsp_finished        = rsp_finished_ff;
   assign rsp_completion_time = rsp_completion_time_ff;
   assign rsp_turnaround      = rsp_turnaround_ff;
   assign rsp_waiting         = rsp_waiting_ff;
   assign rsp_response        = rsp_response_ff;
   assign rsp_all_done        = rsp_all_done_ff;

   // Every update cycle produces exactly one response strobe.
   a_update_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> rsp_valid)
      else $error("update cycle without a response");

   // A response only follows an update cycle.
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_UPDATE))
      else $error("response without an update cycle");

   // More processes can never be finished than were loaded.
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      finished_ff <= loaded_ff)
      else $error("finished count exceeds loaded count");

   // A completion is only reported for a tick that ran a process.
   a_finish_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> !rsp_idle)
      else $error("completion reported on an idle tick");

endmodule

@@ tb/tb_preemptive_priority_scheduler_unit.sv @@
`timescale 1ns / 100ps

// The bench feeds add and tick requests to the scheduler through a queue, predicts every
// tick response with its own model of the process table, and checks each response as it
// comes out.
module tb_preemptive_priority_scheduler_unit import pps_pkg::*; ();

   // Everything one request carries, plus how the driver should present it.
   typedef struct {
      logic              op;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRI_W-1:0]  prio;
      int unsigned       gap;          // idle cycles on start before this request
      bit                drain_first;  // hold off until every tick response is back
   } sched_request_type;

   // One tick response as the scheduler should report it.
   typedef struct {
      logic [TIME_W-1:0] tick_time;
      logic              idle;
      logic [RID_W-1:0]  running_id;
      logic              finished;
      logic [TIME_W-1:0] completion_time;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic [TIME_W-1:0] response;
      logic              all_done;
   } tick_report_type;

   localparam int unsigned RANDOM_REQUESTS  = 750;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_operation = OP_ADD;
   logic [TIME_W-1:0] req_arrival_time = '0;
   logic [TIME_W-1:0] req_burst_length = '0;
   logic [PRI_W-1:0]  req_priority_level = '0;
   logic              rsp_valid;
   logic [TIME_W-1:0] rsp_tick_time;
   logic              rsp_idle;
   logic [RID_W-1:0]  rsp_running_id;
   logic              rsp_finished;
   logic [TIME_W-1:0] rsp_completion_time;
   logic [TIME_W-1:0] rsp_turnaround;
   logic [TIME_W-1:0] rsp_waiting;
   logic [TIME_W-1:0] rsp_response;
   logic              rsp_all_done;

   preemptive_priority_scheduler_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_arrival_time    (req_arrival_time),
      .req_burst_length    (req_burst_length),
      .req_priority_level  (req_priority_level),
      .rsp_valid           (rsp_valid),
      .rsp_tick_time       (rsp_tick_time),
      .rsp_idle            (rsp_idle),
      .rsp_running_id      (rsp_running_id),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_waiting         (rsp_waiting),
      .rsp_response        (rsp_response),
      .rsp_all_done        (rsp_all_done)
   );

   always #2 clock = ~clock;

   // Requests waiting for the driver, and tick responses waiting to be seen.
   sched_request_type pending_requests[$];
   tick_report_type   tick_reports_due[$];

   // The bench's own copy of the process table and scheduler clock.
   logic [TIME_W-1:0] proc_arrival[MAX_PROCESSES];
   logic [TIME_W-1:0] proc_burst[MAX_PROCESSES];
   logic [TIME_W-1:0] proc_left[MAX_PROCESSES];
   logic [PRI_W-1:0]  proc_prio[MAX_PROCESSES];
   logic [TIME_W-1:0] proc_resp[MAX_PROCESSES];
   bit                proc_started[MAX_PROCESSES];
   logic [TIME_W-1:0] sched_now = '0;
   int                procs_loaded = 0;
   int                procs_done = 0;

   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                cycle_limit = 0;
   longint            cycle_budget = 0;

   // Time the scheduler will show once every request queued so far has been taken. Every
   // tick advances the clock by exactly one, so the generator can aim arrivals at it.
   logic [TIME_W-1:0] gen_time = '0;

   // Driver bookkeeping.
   bit                req_taken = 1'b0;
   bit                staged = 1'b0;
   bit                launch;
   int unsigned       gap_left = 0;
   sched_request_type next_req;
   tick_report_type   seen_due;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string fname, input int unsigned seen,
                              input int unsigned due);
      if (seen != due)
         report_mismatch($sformatf("%s is %0d, %0d was due", fname, seen, due));
   endtask

   // Applies one accepted request to the table copy. A tick queues the response that it
   // must produce; an add produces none, and one to a full table changes nothing.
   task automatic predict_schedule(input logic op, input logic [TIME_W-1:0] arr,
                                   input logic [TIME_W-1:0] bur,
                                   input logic [PRI_W-1:0] pri);
      int                best;
      bit                found;
      tick_report_type   rep;
      logic [TIME_W-1:0] finish_at;
      logic [TIME_W-1:0] turn;
      best = 0;
      found = 1'b0;
      rep = '{default: '0};
      if (op == OP_ADD) begin
         if (procs_loaded < MAX_PROCESSES) begin
            proc_arrival[procs_loaded] = arr;
            proc_burst[procs_loaded]   = bur;
            proc_left[procs_loaded]    = bur;
            proc_prio[procs_loaded]    = pri;
            proc_resp[procs_loaded]    = '0;
            proc_started[procs_loaded] = 1'b0;
            procs_loaded++;
            // A process with no work counts as finished the moment it is loaded.
            if (bur == '0)
               procs_done++;
         end
      end else begin
         // Lowest priority value wins; a tie goes to the earlier arrival, and a full tie
         // to the lower id, since a later row only replaces on a strict improvement.
         for (int i = 0; i < procs_loaded; i++) begin
            if (proc_left[i] != '0 && proc_arrival[i] <= sched_now) begin
               if (!found || proc_prio[i] < proc_prio[best] ||
                   (proc_prio[i] == proc_prio[best] &&
                    proc_arrival[i] < proc_arrival[best])) begin
                  best = i;
                  found = 1'b1;
               end
            end
         end
         rep.tick_time = sched_now;
         if (!found) begin
            rep.idle = 1'b1;
         end else begin
            rep.running_id = RID_W'(best);
            if (!proc_started[best]) begin
               proc_started[best] = 1'b1;
               proc_resp[best] = sched_now - proc_arrival[best];
            end
            proc_left[best] = proc_left[best] - 1'b1;
            if (proc_left[best] == '0) begin
               // All figures are differences modulo the 16-bit clock.
               finish_at = sched_now + 1'b1;
               turn = finish_at - proc_arrival[best];
               procs_done++;
               rep.finished        = 1'b1;
               rep.completion_time = finish_at;
               rep.turnaround      = turn;
               rep.waiting         = turn - proc_burst[best];
               rep.response        = proc_resp[best];
            end
         end
         sched_now = sched_now + 1'b1;
         rep.all_done = (procs_done == procs_loaded);
         tick_reports_due.push_back(rep);
      end
   endtask

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   task automatic queue_request(input logic op, input logic [TIME_W-1:0] arr,
                                input logic [TIME_W-1:0] bur,
                                input logic [PRI_W-1:0] pri,
                                input int unsigned gap, input bit drain_first);
      sched_request_type req;
      req.op          = op;
      req.arrival     = arr;
      req.burst       = bur;
      req.prio        = pri;
      req.gap         = gap;
      req.drain_first = drain_first;
      pending_requests.push_back(req);
      if (op == OP_TICK)
         gen_time = gen_time + 1'b1;
      // Worst case per request: its gap, a full-table scan, the response and some slack.
      cycle_budget += gap + MAX_PROCESSES + 8;
   endtask

   // The operand fields of a tick are ignored by the block, so they carry random noise.
   task automatic queue_tick(input int unsigned gap, input bit drain_first);
      queue_request(OP_TICK, TIME_W'($urandom), TIME_W'($urandom), PRI_W'($urandom),
                    gap, drain_first);
   endtask

   task automatic build_stimulus();
      int unsigned       r;
      bit                quiet;
      logic [TIME_W-1:0] arr;
      logic [TIME_W-1:0] bur;
      logic [PRI_W-1:0]  pri;

      // Directed part, starting at time 0.
      queue_tick(pick_gap(), 1'b0);                              // idle on an empty table
      queue_request(OP_ADD, 16'd0, 16'd0, 8'd0, pick_gap(), 1'b0); // zero burst: done at once
      queue_tick(pick_gap(), 1'b0);                              // idle, all done
      queue_request(OP_ADD, 16'd2, 16'd1, 8'd0, pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b0);                              // runs and finishes at once
      // Longest burst, worst priority: ready only from time 7 on.
      queue_request(OP_ADD, 16'd7, 16'hFFFF, 8'hFF, pick_gap(), 1'b0);
      queue_request(OP_ADD, 16'd3, 16'd2, 8'd0, pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b0);
      // Same priority with an earlier arrival preempts the running process.
      queue_request(OP_ADD, 16'd0, 16'd2, 8'd0, pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b0);                              // time 7, long process runs
      queue_tick(pick_gap(), 1'b1);                              // long process keeps running
      queue_request(OP_ADD, 16'd0, 16'd3, 8'd9, pick_gap(), 1'b0);
      queue_request(OP_ADD, 16'd0, 16'd1, 8'd9, pick_gap(), 1'b0); // full tie, lower id wins
      queue_tick(pick_gap(), 1'b0);
      queue_request(OP_ADD, 16'd1, 16'd1, 8'd8, pick_gap(), 1'b0); // better priority preempts
      queue_tick(pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b0);
      queue_tick(pick_gap(), 1'b1);

      // Random part. Adds are spread out so that the remaining rows fill over a long
      // stretch; once the table is full further adds are dropped and act as noise.
      quiet = 1'b0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0)
            quiet = 1'b1;
         else if (n % 100 == 30)
            quiet = 1'b0;
         if ($urandom_range(0, 29) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 55)
               arr = gen_time + TIME_W'($urandom_range(0, 30));
            else if (r < 85)
               arr = gen_time - TIME_W'($urandom_range(0, 20));
            else
               arr = TIME_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 80)
               bur = TIME_W'($urandom_range(1, 12));
            else if (r < 95)
               bur = TIME_W'($urandom_range(13, 120));
            else
               bur = TIME_W'($urandom_range(1, 65535));
            pri = ($urandom_range(0, 1) == 0) ? PRI_W'($urandom_range(0, 7))
                                              : PRI_W'($urandom);
            queue_request(OP_ADD, arr, bur, pri, quiet ? 0 : pick_gap(),
                          $urandom_range(0, 49) == 0);
         end else begin
            queue_tick(quiet ? 0 : pick_gap(), $urandom_range(0, 49) == 0);
         end
      end
   endtask

   // Monitor: samples at the rising edge. A response is checked against the oldest
   // prediction; a request taken at this edge is then applied to the table copy.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (tick_reports_due.size() == 0) begin
               report_mismatch("tick response arrived with none pending");
            end else begin
               seen_due = tick_reports_due.pop_front();
               check_field("tick_time", rsp_tick_time, seen_due.tick_time);
               check_field("idle", rsp_idle, seen_due.idle);
               check_field("running_id", rsp_running_id, seen_due.running_id);
               check_field("finished", rsp_finished, seen_due.finished);
               check_field("completion_time", rsp_completion_time,
                           seen_due.completion_time);
               check_field("turnaround", rsp_turnaround, seen_due.turnaround);
               check_field("waiting", rsp_waiting, seen_due.waiting);
               check_field("response", rsp_response, seen_due.response);
               check_field("all_done", rsp_all_done, seen_due.all_done);
            end
         end
         if (start && !busy)
            predict_schedule(req_operation, req_arrival_time, req_burst_length,
                             req_priority_level);
         req_taken <= start && !busy;
      end
   end

   // Driver: changes inputs at the falling edge. A request stays on the ports with start
   // high until it is taken; the next one may follow at once, keeping start high, or after
   // its gap. A request marked to drain waits until no tick response is outstanding.
   always @(negedge clock) begin
      if (!reset) begin
         launch = start;
         if (start && req_taken)
            launch = 1'b0;
         if (!launch && !staged && pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            gap_left = next_req.gap;
            staged = 1'b1;
         end
         if (!launch && staged) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!next_req.drain_first || tick_reports_due.size() == 0) begin
               req_operation      <= next_req.op;
               req_arrival_time   <= next_req.arrival;
               req_burst_length   <= next_req.burst;
               req_priority_level <= next_req.prio;
               launch = 1'b1;
               staged = 1'b0;
            end
         end
         start <= launch;
      end
   end

   // Watchdog: a run that hangs or loses a response ends here.
   initial begin
      wait (cycle_limit != 0);
      while (cycle_count < cycle_limit)
         @(posedge clock);
      $display("FAIL preemptive_priority_scheduler_unit");
      $finish;
   end

   initial begin
      build_stimulus();
      cycle_limit = int'(4 * cycle_budget + 2000);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Wait for the last request to be taken, then for its response, then a little
      // longer than a full-table tick so that a stray response would still be caught.
      while (pending_requests.size() > 0 || staged || start)
         @(posedge clock);
      while (tick_reports_due.size() > 0)
         @(posedge clock);
      repeat (3 * (MAX_PROCESSES + 4)) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS preemptive_priority_scheduler_unit");
      else
         $display("FAIL preemptive_priority_scheduler_unit");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/pps_pkg.sv
rtl/core/pps_ram.sv
rtl/core/pps_scan.sv
rtl/core/preemptive_priority_scheduler_unit.sv
tb/tb_preemptive_priority_scheduler_unit.sv
